/* hw/rtl/sdoc_pkg.sv */
// Shared widths, result codes and stage sideband type for the sprite depth order compare.
package sdoc_pkg;

    localparam int LAYER_W = 16;
    localparam int SLOPE_W = 32;
    localparam int POS_W   = 16;
    localparam int IDENT_W = 32;
    localparam int DX_W    = POS_W + 1;
    localparam int PROD_W  = DX_W + SLOPE_W;
    localparam int FRAC_W  = 16;
    localparam int PROJ_W  = POS_W + 2;
    localparam int ORDER_W = 2;

    localparam logic [ORDER_W-1:0] ORDER_AFTER  = 2'b01;
    localparam logic [ORDER_W-1:0] ORDER_BEFORE = 2'b11;
    localparam logic [ORDER_W-1:0] ORDER_ABSENT = 2'b00;

    // Per-item control carried alongside the projection pipeline.
    typedef struct packed {
        logic                      absent;
        logic                      layer_done;
        logic [ORDER_W-1:0]        layer_order;
        logic                      tie_after;
        logic                      slope_a_nz;
        logic                      slope_b_nz;
        logic signed [POS_W-1:0]   pos_y_a;
        logic signed [POS_W-1:0]   pos_y_b;
    } t_side;

endpackage

/* hw/rtl/sdoc_proj.sv */
// Two-stage slope projection: registered multiply, then truncate, wrap and add y.
module sdoc_proj (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [sdoc_pkg::DX_W-1:0]       i_dx,
    input  logic signed [sdoc_pkg::SLOPE_W-1:0]    i_slope,
    input  logic signed [sdoc_pkg::POS_W-1:0]      i_y,
    output logic signed [sdoc_pkg::PROJ_W-1:0]     o_proj
);

    logic signed [sdoc_pkg::PROD_W-1:0]  r_prod;
    logic signed [sdoc_pkg::POS_W-1:0]   r_y;
    logic signed [sdoc_pkg::PROJ_W-1:0]  r_proj;

    logic signed [sdoc_pkg::PROD_W-1:0]  n_prod;
    logic [2*sdoc_pkg::FRAC_W-1:0]       w_bias;
    logic [2*sdoc_pkg::FRAC_W-1:0]       w_sum;
    logic signed [sdoc_pkg::POS_W-1:0]   w_low;
    logic signed [sdoc_pkg::PROJ_W-1:0]  n_proj;

    assign n_prod = sdoc_pkg::PROD_W'(i_dx) * sdoc_pkg::PROD_W'(i_slope);

    // Truncation toward zero: bias negative products by 2^16-1 before the shift.
    assign w_bias = r_prod[sdoc_pkg::PROD_W-1]
                  ? (2*sdoc_pkg::FRAC_W)'((1 << sdoc_pkg::FRAC_W) - 1)
                  : '0;
    assign w_sum  = r_prod[2*sdoc_pkg::FRAC_W-1:0] + w_bias;
    assign w_low  = $signed(w_sum[2*sdoc_pkg::FRAC_W-1:sdoc_pkg::FRAC_W]);
    assign n_proj = sdoc_pkg::PROJ_W'(w_low) + sdoc_pkg::PROJ_W'(r_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_y    <= i_y;
            r_proj <= n_proj;
        end
    end

    assign o_proj = r_proj;

endmodule

/* hw/rtl/sprite_depth_order_compare_core.sv */
// Top level of the sprite depth order compare: skid stage, four-stage pipeline, decision.
// Stages in order: input reg, multiply, project, decide/output reg; an item parked in the
//   input skid register enters the input reg once the pipe advances.
// Throughput: one pair per cycle; the two 17x32 projection multipliers are fully pipelined.
// Backpressure stalls every stage together; a one-entry skid register decouples o_in_ready
//   from i_out_ready so the input side never sees a combinational path from the output side.
// Reset (i_rst_n, synchronous, active low) clears all valid bits; payload is not reset.
module sprite_depth_order_compare_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [sdoc_pkg::LAYER_W-1:0]   i_layer_a,
    input  logic signed [sdoc_pkg::LAYER_W-1:0]   i_layer_b,
    input  logic signed [sdoc_pkg::SLOPE_W-1:0]   i_slope_a,
    input  logic signed [sdoc_pkg::SLOPE_W-1:0]   i_slope_b,
    input  logic signed [sdoc_pkg::POS_W-1:0]     i_pos_x_a,
    input  logic signed [sdoc_pkg::POS_W-1:0]     i_pos_y_a,
    input  logic signed [sdoc_pkg::POS_W-1:0]     i_pos_x_b,
    input  logic signed [sdoc_pkg::POS_W-1:0]     i_pos_y_b,
    input  logic [sdoc_pkg::IDENT_W-1:0]          i_ident_a,
    input  logic [sdoc_pkg::IDENT_W-1:0]          i_ident_b,

    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [sdoc_pkg::ORDER_W-1:0]   o_order
);

    // Input transaction payload, grouped for the skid register.
    typedef struct packed {
        logic signed [sdoc_pkg::LAYER_W-1:0] layer_a;
        logic signed [sdoc_pkg::LAYER_W-1:0] layer_b;
        logic signed [sdoc_pkg::SLOPE_W-1:0] slope_a;
        logic signed [sdoc_pkg::SLOPE_W-1:0] slope_b;
        logic signed [sdoc_pkg::POS_W-1:0]   pos_x_a;
        logic signed [sdoc_pkg::POS_W-1:0]   pos_y_a;
        logic signed [sdoc_pkg::POS_W-1:0]   pos_x_b;
        logic signed [sdoc_pkg::POS_W-1:0]   pos_y_b;
        logic [sdoc_pkg::IDENT_W-1:0]        ident_a;
        logic [sdoc_pkg::IDENT_W-1:0]        ident_b;
    } t_item;

    // Whole pipeline advances when the output register is empty or being drained.
    logic w_en;
    assign w_en = !o_out_valid || i_out_ready;

    // ---------------- skid register ----------------
    logic  r_skid_v;
    t_item r_skid;
    t_item w_in;
    t_item w_src;
    logic  w_src_v;

    assign o_in_ready = !r_skid_v;

    assign w_in = '{layer_a: i_layer_a, layer_b: i_layer_b,
                    slope_a: i_slope_a, slope_b: i_slope_b,
                    pos_x_a: i_pos_x_a, pos_y_a: i_pos_y_a,
                    pos_x_b: i_pos_x_b, pos_y_b: i_pos_y_b,
                    ident_a: i_ident_a, ident_b: i_ident_b};

    assign w_src_v = r_skid_v || i_in_valid;
    assign w_src   = r_skid_v ? r_skid : w_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_skid_v <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && i_in_valid && o_in_ready) begin
            r_skid <= w_in;
        end
    end

    // ---------------- stage 1: layers, flags, x deltas ----------------
    logic                                 r_s1_v;
    sdoc_pkg::t_side                      r_s1_side;
    logic signed [sdoc_pkg::DX_W-1:0]     r_s1_dx_ab;
    logic signed [sdoc_pkg::DX_W-1:0]     r_s1_dx_ba;
    logic signed [sdoc_pkg::SLOPE_W-1:0]  r_s1_slope_a;
    logic signed [sdoc_pkg::SLOPE_W-1:0]  r_s1_slope_b;

    sdoc_pkg::t_side                      n_s1_side;
    logic                                 w_layered;

    // Layers only count when both are strictly positive.
    assign w_layered = (w_src.layer_a > 0) && (w_src.layer_b > 0);

    always_comb begin
        n_s1_side             = '0;
        n_s1_side.absent      = (w_src.ident_a == '0) || (w_src.ident_b == '0);
        n_s1_side.layer_done  = w_layered && (w_src.layer_a != w_src.layer_b);
        n_s1_side.layer_order = (w_src.layer_a > w_src.layer_b)
                              ? sdoc_pkg::ORDER_AFTER : sdoc_pkg::ORDER_BEFORE;
        n_s1_side.tie_after   = w_src.ident_b < w_src.ident_a;
        n_s1_side.slope_a_nz  = w_src.slope_a != '0;
        n_s1_side.slope_b_nz  = w_src.slope_b != '0;
        n_s1_side.pos_y_a     = w_src.pos_y_a;
        n_s1_side.pos_y_b     = w_src.pos_y_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= w_src_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side    <= n_s1_side;
            r_s1_dx_ab   <= sdoc_pkg::DX_W'(w_src.pos_x_b) - sdoc_pkg::DX_W'(w_src.pos_x_a);
            r_s1_dx_ba   <= sdoc_pkg::DX_W'(w_src.pos_x_a) - sdoc_pkg::DX_W'(w_src.pos_x_b);
            r_s1_slope_a <= w_src.slope_a;
            r_s1_slope_b <= w_src.slope_b;
        end
    end

    // ---------------- stages 2 and 3: projections ----------------
    logic signed [sdoc_pkg::PROJ_W-1:0] w_proj_a;
    logic signed [sdoc_pkg::PROJ_W-1:0] w_proj_b;

    sdoc_proj u_proj_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dx    (r_s1_dx_ab),
        .i_slope (r_s1_slope_a),
        .i_y     (r_s1_side.pos_y_a),
        .o_proj  (w_proj_a)
    );

    sdoc_proj u_proj_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dx    (r_s1_dx_ba),
        .i_slope (r_s1_slope_b),
        .i_y     (r_s1_side.pos_y_b),
        .o_proj  (w_proj_b)
    );

    logic            r_s2_v;
    logic            r_s3_v;
    sdoc_pkg::t_side r_s2_side;
    sdoc_pkg::t_side r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side <= r_s1_side;
            r_s3_side <= r_s2_side;
        end
    end

    // ---------------- stage 4: decision and output register ----------------
    logic signed [sdoc_pkg::PROJ_W-1:0] w_ya;
    logic signed [sdoc_pkg::PROJ_W-1:0] w_yb;
    logic [sdoc_pkg::ORDER_W-1:0]       w_tie;
    logic [sdoc_pkg::ORDER_W-1:0]       w_plain;
    logic                               w_front;
    logic [sdoc_pkg::ORDER_W-1:0]       n_order;

    assign w_ya    = sdoc_pkg::PROJ_W'(r_s3_side.pos_y_a);
    assign w_yb    = sdoc_pkg::PROJ_W'(r_s3_side.pos_y_b);
    assign w_tie   = r_s3_side.tie_after ? sdoc_pkg::ORDER_AFTER : sdoc_pkg::ORDER_BEFORE;
    assign w_plain = (w_ya > w_yb) ? sdoc_pkg::ORDER_AFTER
                   : (w_ya < w_yb) ? sdoc_pkg::ORDER_BEFORE : w_tie;
    assign w_front = w_proj_a > w_yb;

    always_comb begin
        if (r_s3_side.absent) begin
            n_order = sdoc_pkg::ORDER_ABSENT;
        end else if (r_s3_side.layer_done) begin
            n_order = r_s3_side.layer_order;
        end else if (r_s3_side.slope_a_nz && r_s3_side.slope_b_nz) begin
            // Both slopes: both projections must agree, else fall back to plain y.
            if ((w_ya > w_proj_b) && w_front) begin
                n_order = sdoc_pkg::ORDER_AFTER;
            end else if ((w_ya < w_proj_b) && !w_front) begin
                n_order = sdoc_pkg::ORDER_BEFORE;
            end else begin
                n_order = w_plain;
            end
        end else if (r_s3_side.slope_a_nz) begin
            n_order = (w_proj_a > w_yb) ? sdoc_pkg::ORDER_AFTER
                    : (w_proj_a == w_yb) ? w_tie : sdoc_pkg::ORDER_BEFORE;
        end else if (r_s3_side.slope_b_nz) begin
            n_order = (w_ya > w_proj_b) ? sdoc_pkg::ORDER_AFTER
                    : (w_ya == w_proj_b) ? w_tie : sdoc_pkg::ORDER_BEFORE;
        end else begin
            n_order = w_plain;
        end
    end

    logic                          r_out_v;
    logic [sdoc_pkg::ORDER_W-1:0]  r_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_order <= n_order;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_order     = $signed(r_order);

    // ---------------- assertions ----------------
    // Skid register only fills while the output is stalled.
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready))
        else $error("skid filled without output stall");

    // The encoding 2'b10 is never produced.
    a_order_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_order != 2'sb10))
        else $error("illegal order code");

    // A finished item in stage 3 reaches the output when the pipe advances.
    a_s3_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && w_en) |=> r_out_v)
        else $error("stage 3 transaction lost");

    // A stalled pipe keeps its stage 1 transaction.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !w_en) |=> r_s1_v)
        else $error("stage 1 transaction dropped during stall");

endmodule

/* tb/sdoc_order_checker.sv */
// Channel monitor, draw order predictor and result scoreboard for the sprite depth order compare.
`timescale 1ns / 100ps

module sdoc_order_checker
    import sdoc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic signed [LAYER_W-1:0]   i_layer_a,
    input  logic signed [LAYER_W-1:0]   i_layer_b,
    input  logic signed [SLOPE_W-1:0]   i_slope_a,
    input  logic signed [SLOPE_W-1:0]   i_slope_b,
    input  logic signed [POS_W-1:0]     i_pos_x_a,
    input  logic signed [POS_W-1:0]     i_pos_y_a,
    input  logic signed [POS_W-1:0]     i_pos_x_b,
    input  logic signed [POS_W-1:0]     i_pos_y_b,
    input  logic [IDENT_W-1:0]          i_ident_a,
    input  logic [IDENT_W-1:0]          i_ident_b,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [ORDER_W-1:0]   i_order,
    input  logic                        i_end_of_test,
    output int                          o_pending,
    output int                          o_fail_count
);

    logic [ORDER_W-1:0] pending_orders[$];
    int                 pending_n  = 0;
    int                 fail_total = 0;

    // y plus the slope-scaled x distance, truncated toward zero and wrapped to 16 bits
    function automatic int project_y(input int dx, input logic signed [SLOPE_W-1:0] slope,
                                     input int y);
        longint prod;
        longint mag;
        logic [POS_W-1:0] low;
        prod = longint'(dx) * longint'(slope);
        if (prod < 0) begin
            mag = (-prod) >>> FRAC_W;
            low = POS_W'(-mag);
        end else begin
            low = POS_W'(prod >>> FRAC_W);
        end
        return int'($signed(low)) + y;
    endfunction

    function automatic logic [ORDER_W-1:0] id_tiebreak(input logic [IDENT_W-1:0] ida,
                                                       input logic [IDENT_W-1:0] idb);
        return (idb < ida) ? ORDER_AFTER : ORDER_BEFORE;
    endfunction

    function automatic logic [ORDER_W-1:0] predict_order(
        input logic signed [LAYER_W-1:0] la, input logic signed [LAYER_W-1:0] lb,
        input logic signed [SLOPE_W-1:0] sa, input logic signed [SLOPE_W-1:0] sb,
        input logic signed [POS_W-1:0] xa, input logic signed [POS_W-1:0] ya,
        input logic signed [POS_W-1:0] xb, input logic signed [POS_W-1:0] yb,
        input logic [IDENT_W-1:0] ida, input logic [IDENT_W-1:0] idb);
        int from_a;
        int from_b;
        int ay;
        int by;
        ay = int'(ya);
        by = int'(yb);
        if (ida == '0 || idb == '0)
            return ORDER_ABSENT;
        if (la > 0 && lb > 0 && la != lb)
            return (la > lb) ? ORDER_AFTER : ORDER_BEFORE;
        if (sa != 0 && sb != 0) begin
            from_a = project_y(int'(xb) - int'(xa), sa, ay);
            from_b = project_y(int'(xa) - int'(xb), sb, by);
            if (ay > from_b && from_a > by)
                return ORDER_AFTER;
            if (ay < from_b && from_a <= by)
                return ORDER_BEFORE;
        end else if (sa != 0) begin
            from_a = project_y(int'(xb) - int'(xa), sa, ay);
            if (from_a == by)
                return id_tiebreak(ida, idb);
            return (from_a > by) ? ORDER_AFTER : ORDER_BEFORE;
        end else if (sb != 0) begin
            from_b = project_y(int'(xa) - int'(xb), sb, by);
            if (ay == from_b)
                return id_tiebreak(ida, idb);
            return (ay > from_b) ? ORDER_AFTER : ORDER_BEFORE;
        end
        if (ay == by)
            return id_tiebreak(ida, idb);
        return (ay > by) ? ORDER_AFTER : ORDER_BEFORE;
    endfunction

    // leftovers at the end of the test count as failures
    assign o_pending    = pending_n;
    assign o_fail_count = fail_total + (i_end_of_test ? pending_n : 0);

    always @(posedge i_clk) begin
        logic [ORDER_W-1:0] want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                pending_orders.push_back(predict_order(i_layer_a, i_layer_b, i_slope_a,
                    i_slope_b, i_pos_x_a, i_pos_y_a, i_pos_x_b, i_pos_y_b, i_ident_a,
                    i_ident_b));
            if (i_out_valid && i_out_ready) begin
                if (pending_orders.size() == 0) begin
                    $error("order: expected none, actual %0d", i_order);
                    fail_total++;
                end else begin
                    want = pending_orders.pop_front();
                    if (i_order !== want) begin
                        $error("order: expected %0d, actual %0d", $signed(want), i_order);
                        fail_total++;
                    end
                end
            end
            pending_n = pending_orders.size();
        end
    end

    always @(posedge i_end_of_test) begin
        if (pending_orders.size() != 0) begin
            $error("order: expected %0d more results, actual none", pending_orders.size());
        end
    end

endmodule

/* tb/tb_sprite_depth_order_compare_core.sv */
// Top of the sprite depth order compare testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sprite_depth_order_compare_core;
    import sdoc_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_LIMIT  = 4000;     // cycles allowed for the pipe to empty
    localparam int SETTLE       = 10;       // extra wait after the drain, before end_of_test is raised

    // One pair of sprites, as carried by a single input transaction
    typedef struct packed {
        logic signed [LAYER_W-1:0]  layer_a;
        logic signed [LAYER_W-1:0]  layer_b;
        logic signed [SLOPE_W-1:0]  slope_a;
        logic signed [SLOPE_W-1:0]  slope_b;
        logic signed [POS_W-1:0]    pos_x_a;
        logic signed [POS_W-1:0]    pos_y_a;
        logic signed [POS_W-1:0]    pos_x_b;
        logic signed [POS_W-1:0]    pos_y_b;
        logic [IDENT_W-1:0]         ident_a;
        logic [IDENT_W-1:0]         ident_b;
    } t_sprite_pair;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       i_out_ready = 1'b0;
    t_sprite_pair               pair_q = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic signed [ORDER_W-1:0]  o_order;

    logic                       idle_enable = 1'b0;  // random gaps on both sides
    logic                       end_of_test = 1'b0;
    int                         pending;
    int                         fail_count;
    int                         pairs_sent = 0;
    int                         directed_pairs = 0;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sprite_depth_order_compare_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_layer_a   (pair_q.layer_a),
        .i_layer_b   (pair_q.layer_b),
        .i_slope_a   (pair_q.slope_a),
        .i_slope_b   (pair_q.slope_b),
        .i_pos_x_a   (pair_q.pos_x_a),
        .i_pos_y_a   (pair_q.pos_y_a),
        .i_pos_x_b   (pair_q.pos_x_b),
        .i_pos_y_b   (pair_q.pos_y_b),
        .i_ident_a   (pair_q.ident_a),
        .i_ident_b   (pair_q.ident_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_order     (o_order)
    );

    // The checker sees exactly the same pins as the DUT and keeps its own expectations
    sdoc_order_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_layer_a     (pair_q.layer_a),
        .i_layer_b     (pair_q.layer_b),
        .i_slope_a     (pair_q.slope_a),
        .i_slope_b     (pair_q.slope_b),
        .i_pos_x_a     (pair_q.pos_x_a),
        .i_pos_y_a     (pair_q.pos_y_a),
        .i_pos_x_b     (pair_q.pos_x_b),
        .i_pos_y_b     (pair_q.pos_y_b),
        .i_ident_a     (pair_q.ident_a),
        .i_ident_b     (pair_q.ident_b),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_order       (o_order),
        .i_end_of_test (end_of_test),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Receiver: while idling is on, ready drops in roughly a quarter of the cycles
    always @(posedge i_clk) begin
        i_out_ready <= !idle_enable || ($urandom_range(99) >= 25);
    end

    // Hard stop, far beyond any correct run
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_sprite_pair make_pair(input int la, input int lb,
                                               input logic [31:0] sa, input logic [31:0] sb,
                                               input int xa, input int ya,
                                               input int xb, input int yb,
                                               input logic [31:0] ida, input logic [31:0] idb);
        t_sprite_pair p;
        p.layer_a = LAYER_W'(la);
        p.layer_b = LAYER_W'(lb);
        p.slope_a = sa;
        p.slope_b = sb;
        p.pos_x_a = POS_W'(xa);
        p.pos_y_a = POS_W'(ya);
        p.pos_x_b = POS_W'(xb);
        p.pos_y_b = POS_W'(yb);
        p.ident_a = ida;
        p.ident_b = idb;
        return p;
    endfunction

    // Layers: small positive values make equal layers common, so later tests get reached
    function automatic logic signed [LAYER_W-1:0] rand_layer();
        case ($urandom_range(3))
            0:       return LAYER_W'($urandom);
            1, 2:    return LAYER_W'($urandom_range(4, 1));
            default: return LAYER_W'(-int'($urandom_range(3)));
        endcase
    endfunction

    // Slopes: zero, full range, and small Q16.16 values where projections stay on screen
    function automatic logic signed [SLOPE_W-1:0] rand_slope();
        case ($urandom_range(3))
            0:       return '0;
            1:       return SLOPE_W'($urandom);
            2:       return SLOPE_W'(int'($urandom_range(32'h6_0000)) - 32'h3_0000);
            default: return SLOPE_W'((int'($urandom_range(8)) - 4) <<< 15);
        endcase
    endfunction

    // Coordinates: two in five tightly clustered so y and projections collide often
    function automatic logic signed [POS_W-1:0] rand_coord();
        case ($urandom_range(4))
            0, 1:    return POS_W'($urandom);
            2, 3:    return POS_W'(int'($urandom_range(16)) - 8);
            default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // Identities: a few absent, some small so equal identities show up in the tiebreak
    function automatic logic [IDENT_W-1:0] rand_ident();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 25)
            return IDENT_W'($urandom_range(3, 1));
        return IDENT_W'($urandom);
    endfunction

    function automatic t_sprite_pair rand_pair();
        t_sprite_pair p;
        p.layer_a = rand_layer();
        p.layer_b = rand_layer();
        p.slope_a = rand_slope();
        p.slope_b = rand_slope();
        p.pos_x_a = rand_coord();
        p.pos_y_a = rand_coord();
        p.pos_x_b = rand_coord();
        p.pos_y_b = rand_coord();
        p.ident_a = rand_ident();
        p.ident_b = rand_ident();
        return p;
    endfunction

    // Called at a rising-edge step; returns at the edge where the transaction is taken.
    // valid gets exactly one nonblocking write per step, so back-to-back items keep it high.
    task automatic send_pair(input t_sprite_pair p);
        while (idle_enable && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_q     <= p;
        i_in_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pairs_sent++;
    endtask

    // Stop sending and wait, on falling edges, until the checker holds no expectation
    task automatic wait_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_pair(rand_pair());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs, back to back with no gaps
        // absent sprites take precedence over everything else
        send_pair(make_pair(1, 1, 0, 0, 0, 0, 0, 0, 0, 5));
        send_pair(make_pair(1, 1, 0, 0, 0, 0, 0, 0, 5, 0));
        send_pair(make_pair(9, 2, 32'h1_0000, 0, 0, 0, 0, 0, 0, 0));
        // layers decide only when both are positive and differ
        send_pair(make_pair(32767, 1, 0, 0, 0, -5, 0, 5, 1, 2));
        send_pair(make_pair(1, 32767, 0, 0, 0, 5, 0, -5, 1, 2));
        send_pair(make_pair(-32768, 5, 0, 0, 0, 3, 0, 1, 1, 2));
        send_pair(make_pair(3, 3, 0, 0, 0, -32768, 0, 32767, 7, 7));
        // no slopes: y, then identity tiebreak (larger identity after, equal ids before)
        send_pair(make_pair(0, 0, 0, 0, 0, 4, 9, 4, 32'hFFFF_FFFF, 1));
        send_pair(make_pair(0, 0, 0, 0, 0, 4, 9, 4, 1, 32'hFFFF_FFFF));
        send_pair(make_pair(0, 0, 0, 0, 0, 4, 9, 4, 9, 9));
        // only A sloped, projection 5 against yb above, equal, below
        send_pair(make_pair(0, 0, 32'h1_0000, 0, 0, 0, 5, 4, 3, 6));
        send_pair(make_pair(0, 0, 32'h1_0000, 0, 0, 0, 5, 5, 3, 6));
        send_pair(make_pair(0, 0, 32'h1_0000, 0, 0, 0, 5, 6, 3, 6));
        // only B sloped, projection 3 against ya above, equal, below
        send_pair(make_pair(0, 0, 0, 32'h1_0000, 3, 4, 0, 0, 6, 3));
        send_pair(make_pair(0, 0, 0, 32'h1_0000, 3, 3, 0, 0, 6, 3));
        send_pair(make_pair(0, 0, 0, 32'h1_0000, 3, 2, 0, 0, 6, 3));
        // both sloped: clear after, clear before, and the undecided fall-through to y
        send_pair(make_pair(0, 0, 32'h1_0000, 32'h1_0000, 0, 5, 0, 2, 1, 2));
        send_pair(make_pair(0, 0, 32'h1_0000, 32'h1_0000, 0, 2, 0, 5, 1, 2));
        send_pair(make_pair(0, 0, 32'hFFFF_0000, 32'h1_0000, 0, 3, 10, 3, 4, 8));
        // extreme slopes and x spans, projection wraps to 16 bits
        send_pair(make_pair(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, -32768, 32767, 32767, -32768,
                            32'hFFFF_FFFF, 32'hFFFF_FFFE));
        send_pair(make_pair(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32767, -32768, -32768, 32767,
                            32'hFFFF_FFFE, 32'hFFFF_FFFF));
        send_pair(make_pair(-1, -1, 32'h7FFF_FFFF, 0, -32768, 0, 32767, 0, 2, 1));
        // negative products truncate toward zero: -1/65536 gives 0, -1.5 gives -1
        send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, 2, 1));
        send_pair(make_pair(0, 0, 32'hFFFE_8000, 0, 0, 0, 1, -1, 1, 2));
        directed_pairs = pairs_sent;

        // Random traffic with gaps on both sides
        idle_enable <= 1'b1;
        send_random(RANDOM_ITEMS * 2 / 5);

        // Let the whole pipe run dry once before carrying on
        wait_drained();
        @(posedge i_clk);

        // Long stretch at full rate, neither side idling
        idle_enable <= 1'b0;
        send_random(RANDOM_ITEMS / 5);

        idle_enable <= 1'b1;
        send_random(RANDOM_ITEMS - RANDOM_ITEMS * 2 / 5 - RANDOM_ITEMS / 5);

        // Drain, let the pipeline settle, then have the checker flag leftovers
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        end_of_test <= 1'b1;
        @(negedge i_clk);

        $display("Sent %0d pair transactions: %0d directed (absent ids, layers, slope arms,",
                 pairs_sent, directed_pairs);
        $display("truncation, tiebreaks) and the rest random with stalls on both sides.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* sprite_depth_order_compare_core.f */
hw/rtl/sdoc_pkg.sv
hw/rtl/sdoc_proj.sv
hw/rtl/sprite_depth_order_compare_core.sv
tb/sdoc_order_checker.sv
tb/tb_sprite_depth_order_compare_core.sv
